// ===== hdl/bsa_pkg.sv =====
// Shared types, widths and codes for the banker's safety allocator.
package bsa_pkg;

  localparam int MaxProcesses = 8;
  localparam int ResTypes     = 3;
  localparam int RowW         = $clog2(MaxProcesses);
  localparam int CountW       = 4;
  localparam int AmtW         = 8;
  // An allocation plus a request needs one more bit than a stored count.
  localparam int SumW         = AmtW + 1;
  // The work vector can collect every row's allocation on top of the available count.
  localparam int WorkW        = SumW + $clog2(MaxProcesses + 1);
  localparam int DataW        = 32;
  localparam int AddrW        = 3;

  typedef logic [AmtW-1:0]  amt_t;
  typedef logic [SumW-1:0]  sum_t;
  typedef logic [WorkW-1:0] work_t;

  typedef amt_t  [ResTypes-1:0] amt_vec_t;
  typedef sum_t  [ResTypes-1:0] sum_vec_t;
  typedef work_t [ResTypes-1:0] work_vec_t;

  localparam logic [1:0] OpRequest   = 2'd0;
  localparam logic [1:0] OpLoadRow   = 2'd1;
  localparam logic [1:0] OpLoadAvail = 2'd2;

  localparam logic [2:0] StGranted      = 3'd0;
  localparam logic [2:0] StBadId        = 3'd1;
  localparam logic [2:0] StExceedsNeed  = 3'd2;
  localparam logic [2:0] StInsufficient = 3'd3;
  localparam logic [2:0] StUnsafe       = 3'd4;
  localparam logic [2:0] StLoaded       = 3'd5;

  localparam logic [0:0] RegActive = 1'b0;

  localparam logic [CountW-1:0] ActiveReset = CountW'(5);

  typedef struct packed {
    logic                    any;
    logic [MaxProcesses-1:0] pick;
  } pick_t;

endpackage

// ===== hdl/bsa_lane.sv =====
// One process-row lane: tests whether the row's remaining need fits the work vector.
module bsa_lane (
  input  bsa_pkg::work_vec_t work,
  input  bsa_pkg::amt_vec_t  need,
  input  logic               retired,
  output logic               fits
);

  always_comb begin
    fits = !retired;
    for (int r = 0; r < bsa_pkg::ResTypes; r++) begin
      if (work[r] < bsa_pkg::WorkW'(need[r])) begin
        fits = 1'b0;
      end
    end
  end

endmodule

// ===== hdl/bsa_merge.sv =====
// Merging stage: picks the lowest fitting row and adds its allocation to the work vector.
module bsa_merge (
  input  logic [bsa_pkg::MaxProcesses-1:0] fits,
  input  bsa_pkg::sum_vec_t                alloc [bsa_pkg::MaxProcesses],
  input  bsa_pkg::work_vec_t               work,
  output bsa_pkg::pick_t                   sel,
  output bsa_pkg::work_vec_t               work_next
);

  logic [bsa_pkg::MaxProcesses-1:0] pick;
  bsa_pkg::sum_vec_t                chosen;

  // Isolate the lowest set bit.
  assign pick = fits & (~fits + bsa_pkg::MaxProcesses'(1));

  always_comb begin
    chosen = '0;
    for (int p = 0; p < bsa_pkg::MaxProcesses; p++) begin
      for (int r = 0; r < bsa_pkg::ResTypes; r++) begin
        chosen[r] = chosen[r] | (alloc[p][r] & {bsa_pkg::SumW{pick[p]}});
      end
    end
    for (int r = 0; r < bsa_pkg::ResTypes; r++) begin
      work_next[r] = work[r] + bsa_pkg::WorkW'(chosen[r]);
    end
  end

  assign sel.any  = |fits;
  assign sel.pick = pick;

endmodule

// ===== hdl/bankers_safety_allocator_unit.sv =====
// Top level of the banker's safety allocator: ledger, sequencer, lanes and ports.
//
// Use: items enter on in_valid/in_stall with operation, process_id, amount_0..2
// and need_0..2; one status per item leaves on out_valid/out_stall. An item is
// taken at an edge where valid is high and stall is low. Register
// active_processes (APB, byte address 0, reset 5) may be written while idle.
// A load of a process row or of the available vector writes the ledger in the
// execute state and then hands its status to the finish state. A request first
// runs the id, need and availability checks; when those pass, the safety check
// releases fitting rows one at a time and then gives its verdict. The release
// loop is the limit: all row lanes test their need in parallel each cycle, but
// one row's allocation is returned to the work vector per cycle. in_stall is
// high while an item is in work. A finished status waits in the output register
// while out_stall is high; the next item is still accepted meanwhile and parks
// its status until that register frees. Reset clears the ledger to zero, sets
// active_processes to 5 and empties the output register.
module bankers_safety_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsa_pkg::AddrW-1:0]   paddr,
  input  logic [bsa_pkg::DataW-1:0]   pwdata,
  output logic [bsa_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [2:0]                  process_id,
  input  logic [7:0]                  amount_0,
  input  logic [7:0]                  amount_1,
  input  logic [7:0]                  amount_2,
  input  logic [7:0]                  need_0,
  input  logic [7:0]                  need_1,
  input  logic [7:0]                  need_2,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  status
);

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SExec   = 2'd1;
  localparam logic [1:0] SSafe   = 2'd2;
  localparam logic [1:0] SFinish = 2'd3;

  logic [1:0]                      state;
  logic [bsa_pkg::CountW-1:0]      active;
  bsa_pkg::amt_vec_t               avail;
  bsa_pkg::amt_vec_t               alloc [bsa_pkg::MaxProcesses];
  bsa_pkg::amt_vec_t               need  [bsa_pkg::MaxProcesses];
  logic [1:0]                      op;
  logic [bsa_pkg::RowW-1:0]        pid;
  bsa_pkg::amt_vec_t               req;
  bsa_pkg::amt_vec_t               need_in;
  bsa_pkg::work_vec_t              work;
  logic [bsa_pkg::MaxProcesses-1:0] retired;
  logic [2:0]                      result;

  logic [bsa_pkg::CountW-1:0]      n_rows;
  logic                            pid_ok;
  logic                            chk_fail;
  logic [2:0]                      chk_status;
  logic [bsa_pkg::MaxProcesses-1:0] retired_init;
  bsa_pkg::amt_vec_t               lane_need  [bsa_pkg::MaxProcesses];
  bsa_pkg::sum_vec_t               lane_alloc [bsa_pkg::MaxProcesses];
  logic [bsa_pkg::MaxProcesses-1:0] fits;
  bsa_pkg::pick_t                  sel;
  bsa_pkg::work_vec_t              work_next;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[bsa_pkg::AddrW-1] == bsa_pkg::RegActive) ?
                     bsa_pkg::DataW'(active) : '0;
  assign in_stall  = (state != SIdle);

  assign n_rows = (active > bsa_pkg::CountW'(bsa_pkg::MaxProcesses)) ?
                  bsa_pkg::CountW'(bsa_pkg::MaxProcesses) : active;
  assign pid_ok = bsa_pkg::CountW'(pid) < n_rows;

  // Resources are checked in order; the first failing test sets the status.
  always_comb begin
    chk_fail   = 1'b0;
    chk_status = bsa_pkg::StGranted;
    for (int r = 0; r < bsa_pkg::ResTypes; r++) begin
      if (!chk_fail) begin
        if (req[r] > need[pid][r]) begin
          chk_fail   = 1'b1;
          chk_status = bsa_pkg::StExceedsNeed;
        end else if (req[r] > avail[r]) begin
          chk_fail   = 1'b1;
          chk_status = bsa_pkg::StInsufficient;
        end
      end
    end
  end

  // The requesting row is seen with the tentative grant applied.
  always_comb begin
    for (int p = 0; p < bsa_pkg::MaxProcesses; p++) begin
      retired_init[p] = bsa_pkg::CountW'(p) >= n_rows;
      for (int r = 0; r < bsa_pkg::ResTypes; r++) begin
        if (pid == bsa_pkg::RowW'(p)) begin
          lane_need[p][r]  = need[p][r] - req[r];
          lane_alloc[p][r] = bsa_pkg::SumW'(alloc[p][r]) + bsa_pkg::SumW'(req[r]);
        end else begin
          lane_need[p][r]  = need[p][r];
          lane_alloc[p][r] = bsa_pkg::SumW'(alloc[p][r]);
        end
      end
    end
  end

  for (genvar g = 0; g < bsa_pkg::MaxProcesses; g++) begin : g_lane
    bsa_lane u_lane (
      .work    (work),
      .need    (lane_need[g]),
      .retired (retired[g]),
      .fits    (fits[g])
    );
  end

  bsa_merge u_merge (
    .fits      (fits),
    .alloc     (lane_alloc),
    .work      (work),
    .sel       (sel),
    .work_next (work_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SIdle;
      active    <= bsa_pkg::ActiveReset;
      avail     <= '0;
      out_valid <= 1'b0;
      for (int p = 0; p < bsa_pkg::MaxProcesses; p++) begin
        alloc[p] <= '0;
        need[p]  <= '0;
      end
    end else begin
      if (cfg_write && paddr[bsa_pkg::AddrW-1] == bsa_pkg::RegActive) begin
        active <= pwdata[bsa_pkg::CountW-1:0];
      end

      // A finished status loads the output register as soon as it is free.
      if (state == SFinish && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        SIdle: begin
          if (in_valid) begin
            op         <= operation;
            pid        <= process_id;
            req[0]     <= amount_0;
            req[1]     <= amount_1;
            req[2]     <= amount_2;
            need_in[0] <= need_0;
            need_in[1] <= need_1;
            need_in[2] <= need_2;
            state      <= SExec;
          end
        end
        SExec: begin
          state <= SFinish;
          case (op)
            bsa_pkg::OpRequest: begin
              if (!pid_ok) begin
                result <= bsa_pkg::StBadId;
              end else if (chk_fail) begin
                result <= chk_status;
              end else begin
                for (int r = 0; r < bsa_pkg::ResTypes; r++) begin
                  work[r] <= bsa_pkg::WorkW'(avail[r] - req[r]);
                end
                retired <= retired_init;
                state   <= SSafe;
              end
            end
            bsa_pkg::OpLoadRow: begin
              if ((bsa_pkg::RowW + 1)'(pid) >= (bsa_pkg::RowW + 1)'(bsa_pkg::MaxProcesses)) begin
                result <= bsa_pkg::StBadId;
              end else begin
                alloc[pid] <= req;
                need[pid]  <= need_in;
                result     <= bsa_pkg::StLoaded;
              end
            end
            bsa_pkg::OpLoadAvail: begin
              avail  <= req;
              result <= bsa_pkg::StLoaded;
            end
            default: begin
              result <= bsa_pkg::StBadId;
            end
          endcase
        end
        SSafe: begin
          if (&retired) begin
            for (int r = 0; r < bsa_pkg::ResTypes; r++) begin
              avail[r]     <= avail[r] - req[r];
              need[pid][r] <= lane_need[pid][r];
              alloc[pid][r] <= lane_alloc[pid][r][bsa_pkg::AmtW] ?
                               '1 : lane_alloc[pid][r][bsa_pkg::AmtW-1:0];
            end
            result <= bsa_pkg::StGranted;
            state  <= SFinish;
          end else if (sel.any) begin
            retired <= retired | sel.pick;
            work    <= work_next;
          end else begin
            result <= bsa_pkg::StUnsafe;
            state  <= SFinish;
          end
        end
        SFinish: begin
          if (!out_valid || !out_stall) begin
            status <= result;
            state  <= SIdle;
          end
        end
        default: begin
          state <= SIdle;
        end
      endcase
    end
  end

endmodule
